// File: rtl/core/twi_pkg.sv
// shared types and codes for the trie word insert block
// no dependencies
package twi_pkg;

  // word lengths fit in a byte (longest word is 255 bytes)
  localparam int LEN_W = 8;

  // result status codes
  localparam logic [1:0] ST_ADDED   = 2'd0;
  localparam logic [1:0] ST_PRESENT = 2'd1;
  localparam logic [1:0] ST_NOROOM  = 2'd2;
  localparam logic [1:0] ST_EMPTY   = 2'd3;

  // one buffered word as the front hands it to the back
  typedef struct packed {
    logic             over;
    logic [LEN_W-1:0] len;
  } word_entry_t;

  typedef struct packed {
    logic        push;
    word_entry_t entry;
  } word_push_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_READ,
    B_EVAL,
    B_ALLOC1,
    B_ALLOC2,
    B_CHECK,
    B_MREAD,
    B_MEVAL
  } back_state_e;

endpackage

// File: rtl/core/trie_word_insert.sv
// a word that is empty or too long gets its result straight from idle; else the back runs a
// count pass and an insert pass over the trie, with a write per new node and an end-mark step;
// one byte per cycle in unless the queue is full; word rate is set by the node ram port
// reset: store empty (root only, next free node 2), queue and output cleared, no clearing pass
module trie_word_insert #(
  parameter int NODE_COUNT   = 256,
  parameter int MAX_WORD_LEN = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] word_byte_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] status_o,
  output logic [8:0] nodes_used_o
);
  import twi_pkg::*;

  // node index, free count, buffer address and length widths
  localparam int NW   = $clog2(NODE_COUNT);
  localparam int FW   = $clog2(NODE_COUNT + 1);
  localparam int LW   = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
  localparam int LENW = $clog2(MAX_WORD_LEN + 1);

  word_push_t  push;
  word_entry_t head;
  logic        q_full, head_valid, pop;
  logic        buf_we;
  logic [LW:0] buf_waddr, buf_raddr;
  logic [7:0]  buf_wdata, buf_rdata;

  // front collects bytes into one of two word banks
  twi_front #(.MAX_WORD_LEN(MAX_WORD_LEN), .LW(LW), .LENW(LENW)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .word_byte_i (word_byte_i),
    .last_byte_i (last_byte_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .buf_we_o    (buf_we),
    .buf_waddr_o (buf_waddr),
    .buf_wdata_o (buf_wdata)
  );

  // word banks, two of them so a new word fills while the back works
  twi_ram #(.WIDTH(8), .DEPTH(2 * (2 ** LW))) u_word_ram (
    .clk_i   (clk_i),
    .we_i    (buf_we),
    .waddr_i (buf_waddr),
    .wdata_i (buf_wdata),
    .raddr_i (buf_raddr),
    .rdata_o (buf_rdata)
  );

  // the head entry stays until its result is issued, so a full queue owns both banks
  twi_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (q_full),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  twi_back #(
    .NODE_COUNT   (NODE_COUNT),
    .MAX_WORD_LEN (MAX_WORD_LEN),
    .NW           (NW),
    .FW           (FW),
    .LW           (LW),
    .LENW         (LENW)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .buf_raddr_o  (buf_raddr),
    .buf_rdata_i  (buf_rdata),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .nodes_used_o (nodes_used_o)
  );

endmodule

// File: rtl/core/twi_ram.sv
// generic single write port ram with registered read
// no dependencies
module twi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/twi_front.sv
// front part: takes bytes, fills a word bank, hands finished words to the queue
// depends on twi_pkg
module twi_front #(
  parameter int MAX_WORD_LEN = 64,
  parameter int LW           = 6,
  parameter int LENW         = 7
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          word_byte_i,
  input  logic                last_byte_i,
  input  logic                q_full_i,
  output twi_pkg::word_push_t push_o,
  output logic                buf_we_o,
  output logic [LW:0]         buf_waddr_o,
  output logic [7:0]          buf_wdata_o
);
  import twi_pkg::*;

  logic [LENW-1:0] len_q, len_d;
  logic            closed_q, closed_d;
  logic            over_q, over_d;
  logic            bank_q, bank_d;
  logic            accept, store, full_len;
  logic [LENW-1:0] len_n;
  logic            closed_n, over_n;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign full_len   = (len_q == LENW'(MAX_WORD_LEN));
  assign store      = accept && !closed_q && (word_byte_i != 8'd0) && !full_len;

  assign buf_we_o    = store;
  assign buf_waddr_o = {bank_q, len_q[LW-1:0]};
  assign buf_wdata_o = word_byte_i;

  always_comb begin
    len_n    = store ? len_q + LENW'(1) : len_q;
    closed_n = closed_q || (accept && word_byte_i == 8'd0);
    over_n   = over_q || (accept && !closed_q && word_byte_i != 8'd0 && full_len);
    push_o.push       = accept && last_byte_i;
    push_o.entry.len  = LEN_W'(len_n);
    push_o.entry.over = over_n;
    if (accept && last_byte_i) begin
      len_d    = '0;
      closed_d = 1'b0;
      over_d   = 1'b0;
      bank_d   = !bank_q;
    end else begin
      len_d    = len_n;
      closed_d = closed_n;
      over_d   = over_n;
      bank_d   = bank_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q    <= '0;
      closed_q <= 1'b0;
      over_q   <= 1'b0;
      bank_q   <= 1'b0;
    end else begin
      len_q    <= len_d;
      closed_q <= closed_d;
      over_q   <= over_d;
      bank_q   <= bank_d;
    end
  end

endmodule

// File: rtl/core/twi_queue.sv
// two-entry word queue between front and back, one entry per word bank
// depends on twi_pkg
module twi_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  twi_pkg::word_push_t  push_i,
  output logic                 full_o,
  output logic                 head_valid_o,
  output twi_pkg::word_entry_t head_o,
  input  logic                 pop_i
);
  import twi_pkg::*;

  word_entry_t ent_q [2];
  logic        wptr_q, rptr_q;
  logic [1:0]  cnt_q, cnt_d;

  assign full_o       = (cnt_q == 2'd2);
  assign head_valid_o = (cnt_q != 2'd0);
  assign head_o       = ent_q[rptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i.push && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i.push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.push) begin
      ent_q[wptr_q] <= push_i.entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i.push) begin
        wptr_q <= !wptr_q;
      end
      if (pop_i) begin
        rptr_q <= !rptr_q;
      end
      cnt_q <= cnt_d;
    end
  end

endmodule

// File: rtl/core/twi_back.sv
// back part: count pass, capacity check, insert pass over the node store
// depends on twi_pkg and twi_ram
module twi_back #(
  parameter int NODE_COUNT   = 256,
  parameter int MAX_WORD_LEN = 64,
  parameter int NW           = 8,
  parameter int FW           = 9,
  parameter int LW           = 6,
  parameter int LENW         = 7
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 head_valid_i,
  input  twi_pkg::word_entry_t head_i,
  output logic                 pop_o,
  output logic [LW:0]          buf_raddr_o,
  input  logic [7:0]           buf_rdata_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [1:0]           status_o,
  output logic [8:0]           nodes_used_o
);
  import twi_pkg::*;

  localparam int NODE_W = 8 + 2 * NW + 1;
  localparam int NEEDW  = $clog2(2 * MAX_WORD_LEN + 1);
  localparam int SW     = ((FW > NEEDW) ? FW : NEEDW) + 1;

  back_state_e      state_q, state_d;
  logic [NW-1:0]    node_q, node_d;
  logic [LENW-1:0]  pos_q, pos_d;
  logic [NEEDW-1:0] need_q, need_d;
  logic [FW-1:0]    nf_q, nf_d;
  logic             ins_q, ins_d;
  logic             bank_q, bank_d;
  logic             root_vld_q, root_vld_d;
  logic [NW-1:0]    pa_q, pa_d;
  logic [NODE_W-1:0] pd_q, pd_d;
  logic [NW-1:0]    pb_q, pb_d;
  logic             out_valid_q, out_valid_d;
  logic [1:0]       status_q, status_d;
  logic [8:0]       nodes_q, nodes_d;

  logic              n_we;
  logic [NW-1:0]     n_waddr;
  logic [NODE_W-1:0] n_wdata, n_rdata, nd;
  logic [7:0]        sym, c;
  logic [NW-1:0]     child, sib;
  logic              endm, node_zero, sym_hit, last_pos, overflow, start;
  logic [LENW-1:0]   len, pos_inc;
  logic              res_load;
  logic [1:0]        res_status;

  twi_ram #(.WIDTH(NODE_W), .DEPTH(NODE_COUNT)) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (n_we),
    .waddr_i (n_waddr),
    .wdata_i (n_wdata),
    .raddr_i (node_q),
    .rdata_o (n_rdata)
  );

  assign buf_raddr_o = {bank_q, pos_q[LW-1:0]};

  // null node and a never-written root read as cleared
  assign node_zero = (node_q == '0) || (node_q == NW'(1) && !root_vld_q);
  assign nd        = node_zero ? '0 : n_rdata;
  assign sym       = nd[7:0];
  assign child     = nd[8 +: NW];
  assign sib       = nd[8 + NW +: NW];
  assign endm      = nd[NODE_W-1];
  assign c         = buf_rdata_i;
  assign sym_hit   = (sym == c);
  assign len       = LENW'(head_i.len);
  assign pos_inc   = pos_q + LENW'(1);
  assign last_pos  = (pos_inc == len);
  assign overflow  = (SW'(nf_q) + SW'(need_q)) > SW'(NODE_COUNT);
  assign start     = head_valid_i && !out_valid_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: begin
        if (start && len != '0 && !head_i.over) begin
          state_d = B_READ;
        end
      end
      B_READ: state_d = B_EVAL;
      B_EVAL: begin
        if (!ins_q) begin
          if (sym_hit || child == '0 || sib == '0) begin
            state_d = last_pos ? B_CHECK : B_READ;
          end else begin
            state_d = B_READ;
          end
        end else if (sym_hit) begin
          state_d = last_pos ? B_MREAD : B_READ;
        end else if (child == '0) begin
          state_d = B_ALLOC2;
        end else if (sib != '0) begin
          state_d = B_READ;
        end else begin
          state_d = B_ALLOC1;
        end
      end
      B_ALLOC1: state_d = B_ALLOC2;
      B_ALLOC2: state_d = (pos_q == len) ? B_MREAD : B_READ;
      B_CHECK:  state_d = overflow ? B_IDLE : B_READ;
      B_MREAD:  state_d = B_MEVAL;
      B_MEVAL:  state_d = B_IDLE;
      default:  state_d = B_IDLE;
    endcase
  end

  always_comb begin
    node_d     = node_q;
    pos_d      = pos_q;
    need_d     = need_q;
    nf_d       = nf_q;
    ins_d      = ins_q;
    pa_d       = pa_q;
    pd_d       = pd_q;
    pb_d       = pb_q;
    n_we       = 1'b0;
    n_waddr    = node_q;
    n_wdata    = nd;
    res_load   = 1'b0;
    res_status = ST_ADDED;
    case (state_q)
      B_IDLE: begin
        if (start) begin
          if (len == '0) begin
            res_load   = 1'b1;
            res_status = ST_EMPTY;
          end else if (head_i.over) begin
            res_load   = 1'b1;
            res_status = ST_NOROOM;
          end else begin
            node_d = NW'(1);
            pos_d  = '0;
            need_d = '0;
            ins_d  = 1'b0;
          end
        end
      end
      B_EVAL: begin
        if (!ins_q) begin
          if (sym_hit) begin
            node_d = child;
            pos_d  = pos_inc;
          end else if (child == '0) begin
            need_d = need_q + NEEDW'(1);
            node_d = '0;
            pos_d  = pos_inc;
          end else if (sib != '0) begin
            node_d = sib;
          end else begin
            need_d = need_q + NEEDW'(2);
            node_d = '0;
            pos_d  = pos_inc;
          end
        end else if (sym_hit) begin
          node_d = child;
          pos_d  = pos_inc;
        end else if (child == '0) begin
          // take this node for the byte, new child hangs below
          n_we    = 1'b1;
          n_wdata = {endm, sib, NW'(nf_q), c};
          pb_d    = NW'(nf_q);
          node_d  = NW'(nf_q);
          nf_d    = nf_q + FW'(1);
          pos_d   = pos_inc;
        end else if (sib != '0) begin
          node_d = sib;
        end else begin
          // new sibling at the chain end plus its child
          n_we    = 1'b1;
          n_wdata = {endm, NW'(nf_q), child, sym};
          pa_d    = NW'(nf_q);
          pd_d    = {1'b0, {NW{1'b0}}, NW'(nf_q + FW'(1)), c};
          pb_d    = NW'(nf_q + FW'(1));
          node_d  = NW'(nf_q + FW'(1));
          nf_d    = nf_q + FW'(2);
          pos_d   = pos_inc;
        end
      end
      B_ALLOC1: begin
        n_we    = 1'b1;
        n_waddr = pa_q;
        n_wdata = pd_q;
      end
      B_ALLOC2: begin
        n_we    = 1'b1;
        n_waddr = pb_q;
        n_wdata = '0;
      end
      B_CHECK: begin
        if (overflow) begin
          res_load   = 1'b1;
          res_status = ST_NOROOM;
        end else begin
          node_d = NW'(1);
          pos_d  = '0;
          ins_d  = 1'b1;
        end
      end
      B_MEVAL: begin
        res_load = 1'b1;
        if (endm) begin
          res_status = ST_PRESENT;
        end else begin
          n_we       = 1'b1;
          n_wdata    = {1'b1, nd[NODE_W-2:0]};
          res_status = ST_ADDED;
        end
      end
      default: begin
        node_d = node_q;
      end
    endcase
  end

  assign pop_o      = res_load;
  assign bank_d     = res_load ? !bank_q : bank_q;
  assign root_vld_d = root_vld_q || (n_we && n_waddr == NW'(1));

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    status_d    = status_q;
    nodes_d     = nodes_q;
    if (res_load) begin
      out_valid_d = 1'b1;
      status_d    = res_status;
      nodes_d     = 9'(nf_q);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign nodes_used_o = nodes_q;

  always_ff @(posedge clk_i) begin
    pa_q     <= pa_d;
    pd_q     <= pd_d;
    pb_q     <= pb_d;
    status_q <= status_d;
    nodes_q  <= nodes_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      node_q      <= '0;
      pos_q       <= '0;
      need_q      <= '0;
      nf_q        <= FW'(2);
      ins_q       <= 1'b0;
      bank_q      <= 1'b0;
      root_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      node_q      <= node_d;
      pos_q       <= pos_d;
      need_q      <= need_d;
      nf_q        <= nf_d;
      ins_q       <= ins_d;
      bank_q      <= bank_d;
      root_vld_q  <= root_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: rtl/core/twi_checker.sv
// port-level checks for the trie word insert block, bound to the top level
// depends on twi_pkg
module twi_checker #(
  parameter int NODE_COUNT = 256
) (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [7:0] word_byte_i,
  input logic       last_byte_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] status_o,
  input logic [8:0] nodes_used_o
);
  import twi_pkg::*;

  localparam bit SMALL = (NODE_COUNT < 512);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) && $stable(nodes_used_o))
    else $error("stalled result changed");

  // no result while in reset
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("result during reset");

  // node count stays within the store
  a_nodes_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && SMALL |-> nodes_used_o >= 9'd2 && nodes_used_o <= 9'(NODE_COUNT))
    else $error("nodes_used out of range");

  // an added word always owns at least one node beyond the root
  a_added_nodes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && SMALL && status_o == ST_ADDED |-> nodes_used_o >= 9'd3)
    else $error("word added without allocation");

endmodule

bind trie_word_insert twi_checker #(.NODE_COUNT(NODE_COUNT)) u_twi_checker (.*);

// File: bench/trie_word_insert_check.sv
// checker for trie_word_insert: watches both channels, predicts each status item
// from its own copy of the trie and compares; depends on twi_pkg
module trie_word_insert_check #(
  parameter int NODE_COUNT   = 256,
  parameter int MAX_WORD_LEN = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [7:0] word_byte_i,
  input  logic       last_byte_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [1:0] status_i,
  input  logic [8:0] nodes_used_i,
  output int         fail_count_o,
  output int         pending_o
);
  import twi_pkg::*;

  typedef struct packed {
    logic [1:0] status;
    logic [8:0] nodes_used;
  } word_result_t;

  logic [7:0] sym_q [NODE_COUNT];
  logic [7:0] kid_q [NODE_COUNT];
  logic [7:0] sib_q [NODE_COUNT];
  logic       mark_q [NODE_COUNT];
  int         free_q;
  logic [7:0] word_q [MAX_WORD_LEN];
  int         len_q;
  bit         closed_q, over_q;
  word_result_t results_due [$];

  function automatic int node_at(int n);
    return (n < NODE_COUNT) ? n : 0;
  endfunction

  function automatic int take_node();
    int n;
    n = node_at(free_q);
    sym_q[n] = '0; kid_q[n] = '0; sib_q[n] = '0; mark_q[n] = 1'b0;
    free_q++;
    return n;
  endfunction

  // walk the trie; with do_insert clear only the node demand is counted
  function automatic int walk_word(bit do_insert);
    int pos, node, need, s, d;
    logic [7:0] c;
    pos = 0; node = 1; need = 0;
    while (pos < len_q) begin
      c = word_q[pos];
      node = node_at(node);
      if (sym_q[node] == c) begin
        node = kid_q[node]; pos++;
      end else if (kid_q[node] == 0) begin
        need += 1;
        if (do_insert) begin
          sym_q[node] = c;
          d = take_node();
          kid_q[node] = d[7:0];
          node = d;
        end else node = 0;
        pos++;
      end else if (sib_q[node] != 0) begin
        node = sib_q[node];
      end else begin
        need += 2;
        if (do_insert) begin
          s = take_node();
          d = take_node();
          sym_q[s] = c;
          kid_q[s] = d[7:0];
          sib_q[node] = s[7:0];
          node = d;
        end else node = 0;
        pos++;
      end
    end
    if (do_insert) begin
      node = node_at(node);
      if (mark_q[node]) return int'(ST_PRESENT);
      mark_q[node] = 1'b1;
      return int'(ST_ADDED);
    end
    return need;
  endfunction

  function automatic void take_byte(logic [7:0] b, logic last);
    word_result_t r;
    if (!closed_q) begin
      if (b == 8'd0) closed_q = 1'b1;
      else if (len_q < MAX_WORD_LEN) begin
        word_q[len_q] = b;
        len_q++;
      end
      else over_q = 1'b1;
    end
    if (!last) return;
    if (len_q == 0) r.status = ST_EMPTY;
    else if (over_q) r.status = ST_NOROOM;
    else if (free_q + walk_word(1'b0) > NODE_COUNT) r.status = ST_NOROOM;
    else r.status = 2'(walk_word(1'b1));
    r.nodes_used = 9'(free_q);
    results_due.push_back(r);
    len_q = 0; closed_q = 1'b0; over_q = 1'b0;
  endfunction

  always @(posedge clk_i) begin
    word_result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < NODE_COUNT; i++) begin
        sym_q[i] = '0; kid_q[i] = '0; sib_q[i] = '0; mark_q[i] = 1'b0;
      end
      free_q = 2; len_q = 0; closed_q = 1'b0; over_q = 1'b0;
      results_due.delete();
      fail_count_o = 0;
    end else begin
      if (in_valid_i && !in_stall_i) take_byte(word_byte_i, last_byte_i);
      if (out_valid_i && !out_stall_i) begin
        if (results_due.size() == 0) begin
          $display("%0t: unexpected item status=%0d nodes_used=%0d",
                   $time, status_i, nodes_used_i);
          fail_count_o++;
        end else begin
          want = results_due.pop_front();
          if (status_i !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, status_i);
            fail_count_o++;
          end
          if (nodes_used_i !== want.nodes_used) begin
            $display("%0t: nodes_used expected %0d actual %0d",
                     $time, want.nodes_used, nodes_used_i);
            fail_count_o++;
          end
        end
      end
    end
    pending_o = results_due.size();
  end

endmodule

// File: bench/trie_word_insert_test.sv
// top of the trie_word_insert bench: clock, reset, byte stimulus, output stalls
// and the verdict; depends on twi_pkg, trie_word_insert and trie_word_insert_check
module trie_word_insert_test;
  import twi_pkg::*;

  localparam int MAX_LEN = 64;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic [7:0] word_byte_i = 8'd0;
  logic       last_byte_i = 1'b0;
  logic       out_stall_i = 1'b0;
  logic       in_stall_o, out_valid_o;
  logic [1:0] status_o;
  logic [8:0] nodes_used_o;
  int         fail_count, pending;
  bit         hold_off_req = 1'b0;   // asks the receiver for one long hold-off

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  trie_word_insert DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .word_byte_i, .last_byte_i,
    .out_valid_o, .out_stall_i, .status_o, .nodes_used_o
  );

  trie_word_insert_check u_check (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .word_byte_i, .last_byte_i,
    .out_valid_i(out_valid_o), .out_stall_i, .status_i(status_o),
    .nodes_used_i(nodes_used_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  // gap length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // offer one byte and hold it until the block takes it
  task automatic send_byte(logic [7:0] b, logic last, int gap);
    in_valid_i <= 1'b1;
    word_byte_i <= b;
    last_byte_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // whole word from a string, bytes back to back
  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1, 0);
  endtask

  // random word: small alphabet mostly so prefixes are shared and repeats occur
  task automatic send_random_word(output int sent);
    int n, kind;
    logic [7:0] b;
    kind = $urandom_range(0, 99);
    if (kind < 3) n = $urandom_range(MAX_LEN + 1, MAX_LEN + 6);   // too long
    else n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++) begin
      if (kind >= 3 && kind < 80) b = 8'("a") + 8'($urandom_range(0, 3));
      else b = 8'($urandom_range(1, 255));
      if (kind >= 80 && kind < 88 && $urandom_range(0, 3) == 0) b = 8'd0;  // early end
      if (kind >= 88 && kind < 90 && i == 0) b = 8'd0;                    // empty word
      send_byte(b, i == n - 1, pick_gap());
    end
    sent = n;
  endtask

  // receiver: random stalls with calm stretches, plus one long hold-off on request
  initial begin
    int left, cycle;
    bit hold_done;
    left = 0; cycle = 0; hold_done = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      cycle++;
      if (hold_off_req && !hold_done) begin
        out_stall_i <= 1'b1;
        repeat (400) @(posedge clk_i);
        hold_done = 1'b1;
        out_stall_i <= 1'b0;
      end else if (left > 0) begin
        left--;
        out_stall_i <= 1'b1;
      end else if ((cycle / 600) % 4 == 3) begin
        out_stall_i <= 1'b0;   // calm stretch
      end else begin
        case ($urandom_range(0, 49))
          0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12: left = $urandom_range(0, 2);
          13:      left = $urandom_range(10, 40);
          default: left = -1;
        endcase
        out_stall_i <= (left >= 0);
        if (left < 0) left = 0;
      end
    end
  end

  initial begin
    #4000000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int sent, total, waited;
    bit paused;
    total = 0;
    paused = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: new word, repeat, extension, sibling, empty, early end, extreme bytes
    send_text("a");
    send_text("a");
    send_text("ab");
    send_text("b");
    send_byte(8'd0, 1'b1, 0);
    send_byte(8'd0, 1'b0, 0);
    send_byte(8'h41, 1'b1, 0);           // empty word with a trailing ignored byte
    send_byte(8'h63, 1'b0, 0);
    send_byte(8'd0, 1'b0, 0);
    send_byte(8'hff, 1'b1, 0);           // "c", the 0xff is ignored
    send_byte(8'hff, 1'b0, 2);
    send_byte(8'h01, 1'b1, 0);
    send_text("c");                      // present via early-ended word
    send_byte(8'h80, 1'b1, 0);

    // full-size random part
    while (total < 1550) begin
      send_random_word(sent);
      total += sent;
      if (total > 300) hold_off_req = 1'b1;
      if (!paused && total > 800) begin
        paused = 1'b1;
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (pending != 0) @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b0;

    waited = 0;
    while (pending != 0 && waited < 100000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (200) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
